[rtl/async_hdlc_rx_deframer_top_macros.svh]
`ifndef ASYNC_HDLC_RX_DEFRAMER_TOP_MACROS_SVH
`define ASYNC_HDLC_RX_DEFRAMER_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define AHDLC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deframer assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define AHDLC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer assertion failed");

`endif

[rtl/ahdlc_pkg.sv]
package ahdlc_pkg;

  typedef enum logic [1:0] {
    EV_DATA   = 2'd0,
    EV_ACCEPT = 2'd1,
    EV_DROP   = 2'd2
  } event_kind_t;

  typedef enum logic [2:0] {
    ST_NONE    = 3'd0,
    ST_CRC     = 3'd1,
    ST_SHORT   = 3'd2,
    ST_OVERRUN = 3'd3,
    ST_ESCFLAG = 3'd4,
    ST_LINEERR = 3'd5
  } drop_status_t;

  localparam logic [7:0]  FLAG_BYTE = 8'h7e;
  localparam logic [7:0]  ESC_BYTE  = 8'h7d;
  localparam logic [7:0]  ESC_XOR   = 8'h20;
  localparam logic [15:0] FCS_INIT  = 16'hffff;
  localparam logic [15:0] FCS_POLY  = 16'h8408;
  localparam logic [15:0] FCS_GOOD  = 16'hf0b8;
  localparam int          FCS_BYTES = 2;
  localparam int          LEN_W     = 16;
  localparam int          LEN_CMP_W = LEN_W + 1;
  localparam logic        CMD_BYTE  = 1'b0;
  localparam logic        CMD_ERROR = 1'b1;

  function automatic logic [15:0] fcs_update(input logic [15:0] fcs, input logic [7:0] b);
    logic [15:0] f;
    f = fcs ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (f[0]) begin
        f = (f >> 1) ^ FCS_POLY;
      end else begin
        f = f >> 1;
      end
    end
    return f;
  endfunction

endpackage

[rtl/async_hdlc_rx_deframer_top.sv]
// Async HDLC receive deframer: takes one line byte (or a line-error event) per cycle
// and strips 0x7E/0x7D octet stuffing, checks the FCS-16 and emits payload bytes two
// positions late so the FCS never leaves the block. Each accepted input word gives at
// most one output word in the next cycle: a payload byte, a frame-accepted end with its
// length, or a frame drop with its reason; a drop means downstream discards the bytes
// of that frame it already got. Throughput is one word per cycle, set by the single
// FCS/escape update between the input port and the output register; input stalls only
// while the output register holds a word that is itself stalled. The user must write
// max_frame_length (cfg port, always ready) only while the block is idle; unenforced.
`include "async_hdlc_rx_deframer_top_macros.svh"

module async_hdlc_rx_deframer_top #(
  parameter int LENGTH_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_event_kind,
  output logic [7:0]  out_data_byte,
  output logic [2:0]  out_drop_status,
  output logic [15:0] out_frame_length,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_max_frame_length
);

  localparam int CmpW = ahdlc_pkg::LEN_CMP_W;
  localparam int LenW = ahdlc_pkg::LEN_W;

  logic                      in_acc;
  logic [LenW-1:0]           max_len_r;
  logic                      in_escape_r, in_escape_nxt;
  logic [LENGTH_BITS-1:0]    byte_count_r, byte_count_nxt, byte_count_inc;
  logic [15:0]               fcs_r, fcs_nxt;
  logic [7:0]                held0_r, held1_r;
  logic                      shift_en;
  logic [7:0]                ch;
  logic                      data_path;
  logic                      overrun;

  logic                      res_valid;
  ahdlc_pkg::event_kind_t    res_kind;
  logic [7:0]                res_data;
  ahdlc_pkg::drop_status_t   res_status;
  logic [LenW-1:0]           res_len;

  logic                      out_valid_r, out_valid_nxt;
  ahdlc_pkg::event_kind_t    out_kind_r;
  logic [7:0]                out_data_r;
  ahdlc_pkg::drop_status_t   out_status_r;
  logic [LenW-1:0]           out_len_r;

  assign in_stall  = out_valid_r & out_stall;
  assign in_acc    = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;

  assign byte_count_inc = byte_count_r + 1'b1;
  assign overrun = (CmpW'(byte_count_r) >= CmpW'(max_len_r) + CmpW'(ahdlc_pkg::FCS_BYTES))
                 || (&byte_count_r);

  always_comb begin
    res_valid      = 1'b0;
    res_kind       = ahdlc_pkg::EV_DATA;
    res_data       = 8'h00;
    res_status     = ahdlc_pkg::ST_NONE;
    res_len        = '0;
    in_escape_nxt  = in_escape_r;
    byte_count_nxt = byte_count_r;
    fcs_nxt        = fcs_r;
    shift_en       = 1'b0;
    data_path      = 1'b0;
    ch             = in_rx_byte;

    priority if (in_command == ahdlc_pkg::CMD_ERROR) begin
      res_valid  = 1'b1;
      res_kind   = ahdlc_pkg::EV_DROP;
      res_status = ahdlc_pkg::ST_LINEERR;
    end else if (in_escape_r) begin
      in_escape_nxt = 1'b0;
      if (in_rx_byte == ahdlc_pkg::FLAG_BYTE) begin
        res_valid  = 1'b1;
        res_kind   = ahdlc_pkg::EV_DROP;
        res_status = ahdlc_pkg::ST_ESCFLAG;
      end else begin
        ch        = in_rx_byte ^ ahdlc_pkg::ESC_XOR;
        data_path = 1'b1;
      end
    end else if (in_rx_byte == ahdlc_pkg::FLAG_BYTE) begin
      priority if (byte_count_r == '0) begin
        res_valid = 1'b0;
      end else if (fcs_r != ahdlc_pkg::FCS_GOOD) begin
        res_valid  = 1'b1;
        res_kind   = ahdlc_pkg::EV_DROP;
        res_status = ahdlc_pkg::ST_CRC;
      end else if (byte_count_r < LENGTH_BITS'(ahdlc_pkg::FCS_BYTES)) begin
        res_valid  = 1'b1;
        res_kind   = ahdlc_pkg::EV_DROP;
        res_status = ahdlc_pkg::ST_SHORT;
      end else begin
        res_valid = 1'b1;
        res_kind  = ahdlc_pkg::EV_ACCEPT;
        res_len   = LenW'(byte_count_r - LENGTH_BITS'(ahdlc_pkg::FCS_BYTES));
      end
    end else if (in_rx_byte == ahdlc_pkg::ESC_BYTE) begin
      in_escape_nxt = 1'b1;
    end else begin
      data_path = 1'b1;
    end

    if (data_path) begin
      if (overrun) begin
        res_valid  = 1'b1;
        res_kind   = ahdlc_pkg::EV_DROP;
        res_status = ahdlc_pkg::ST_OVERRUN;
      end else begin
        fcs_nxt        = ahdlc_pkg::fcs_update(fcs_r, ch);
        shift_en       = 1'b1;
        byte_count_nxt = byte_count_inc;
        if (byte_count_inc > LENGTH_BITS'(ahdlc_pkg::FCS_BYTES)) begin
          res_valid = 1'b1;
          res_kind  = ahdlc_pkg::EV_DATA;
          res_data  = held0_r;
        end
      end
    end

    // frame end of any kind restarts the frame
    if (res_valid && res_kind != ahdlc_pkg::EV_DATA) begin
      in_escape_nxt  = 1'b0;
      byte_count_nxt = '0;
      fcs_nxt        = ahdlc_pkg::FCS_INIT;
    end
  end

  always_comb begin
    if (in_acc && res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r    <= LenW'(1500);
      in_escape_r  <= 1'b0;
      byte_count_r <= '0;
      fcs_r        <= ahdlc_pkg::FCS_INIT;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        max_len_r <= cfg_max_frame_length;
      end
      if (in_acc) begin
        in_escape_r  <= in_escape_nxt;
        byte_count_r <= byte_count_nxt;
        fcs_r        <= fcs_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && shift_en) begin
      held0_r <= held1_r;
      held1_r <= ch;
    end
    if (in_acc && res_valid) begin
      out_kind_r   <= res_kind;
      out_data_r   <= res_data;
      out_status_r <= res_status;
      out_len_r    <= res_len;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_kind   = out_kind_r;
  assign out_data_byte    = out_data_r;
  assign out_drop_status  = out_status_r;
  assign out_frame_length = out_len_r;

  `AHDLC_ASSERT_NEXT(a_restart_after_end,
    in_acc && res_valid && res_kind != ahdlc_pkg::EV_DATA,
    byte_count_r == '0 && fcs_r == ahdlc_pkg::FCS_INIT && !in_escape_r)
  `AHDLC_ASSERT_NEXT(a_data_after_two_held,
    in_acc && res_valid && res_kind == ahdlc_pkg::EV_DATA,
    byte_count_r > LENGTH_BITS'(ahdlc_pkg::FCS_BYTES))
  `AHDLC_ASSERT_NOW(a_status_only_on_drop,
    out_valid_r && out_kind_r != ahdlc_pkg::EV_DROP,
    out_status_r == ahdlc_pkg::ST_NONE)
  `AHDLC_ASSERT_NEXT(a_load_sets_valid,
    in_acc && res_valid,
    out_valid_r)

endmodule

[tb/tb_async_hdlc_rx_deframer_top.sv]
`timescale 1ns / 1ps

module tb_async_hdlc_rx_deframer_top;

  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [2:0]  status;
    logic [15:0] len;
  } deframe_word_t;

  class deframe_scoreboard;
    logic [15:0]   max_len;
    bit            in_esc;
    logic [15:0]   count;
    logic [15:0]   fcs;
    logic [7:0]    held [2];
    deframe_word_t expected_q [$];
    int            errors;

    function new();
      max_len = 16'd1500;
      errors = 0;
      held[0] = 8'h00;
      held[1] = 8'h00;
      restart();
    endfunction

    function void restart();
      in_esc = 1'b0;
      count = 16'h0000;
      fcs = ahdlc_pkg::FCS_INIT;
    endfunction

    // bitwise LSB-first CRC-16, reflected poly
    function logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int i = 0; i < 8; i++) begin
        fb = c[0] ^ b[i];
        c = c >> 1;
        if (fb) begin
          c = c ^ ahdlc_pkg::FCS_POLY;
        end
      end
      return c;
    endfunction

    function void push(input logic [1:0] k, input logic [7:0] d, input logic [2:0] s,
                       input logic [15:0] l);
      deframe_word_t w;
      w.kind = k;
      w.data = d;
      w.status = s;
      w.len = l;
      expected_q.push_back(w);
    endfunction

    function void drop(input ahdlc_pkg::drop_status_t s);
      restart();
      push(ahdlc_pkg::EV_DROP, 8'h00, s, 16'h0000);
    endfunction

    function void note_word(input logic cmd, input logic [7:0] b);
      logic [7:0] ch;
      logic [7:0] oldest;
      if (cmd == ahdlc_pkg::CMD_ERROR) begin
        drop(ahdlc_pkg::ST_LINEERR);
        return;
      end
      ch = b;
      if (in_esc) begin
        in_esc = 1'b0;
        if (ch == ahdlc_pkg::FLAG_BYTE) begin
          drop(ahdlc_pkg::ST_ESCFLAG);
          return;
        end
        ch = ch ^ ahdlc_pkg::ESC_XOR;
      end else if (ch == ahdlc_pkg::FLAG_BYTE) begin
        if (count == 16'h0000) begin
          return;
        end
        if (fcs != ahdlc_pkg::FCS_GOOD) begin
          drop(ahdlc_pkg::ST_CRC);
        end else if (count < 16'(ahdlc_pkg::FCS_BYTES)) begin
          drop(ahdlc_pkg::ST_SHORT);
        end else begin
          push(ahdlc_pkg::EV_ACCEPT, 8'h00, ahdlc_pkg::ST_NONE,
               count - 16'(ahdlc_pkg::FCS_BYTES));
          restart();
        end
        return;
      end else if (ch == ahdlc_pkg::ESC_BYTE) begin
        in_esc = 1'b1;
        return;
      end
      if ({1'b0, count} >= {1'b0, max_len} + 17'd2 || count == 16'hffff) begin
        drop(ahdlc_pkg::ST_OVERRUN);
        return;
      end
      fcs = crc_step(fcs, ch);
      oldest = held[0];
      held[0] = held[1];
      held[1] = ch;
      count = count + 16'd1;
      if (count > 16'(ahdlc_pkg::FCS_BYTES)) begin
        push(ahdlc_pkg::EV_DATA, oldest, ahdlc_pkg::ST_NONE, 16'h0000);
      end
    endfunction

    function void check_word(input logic [1:0] k, input logic [7:0] d, input logic [2:0] s,
                             input logic [15:0] l);
      deframe_word_t w;
      if (expected_q.size() == 0) begin
        $error("unexpected output word: kind %0d data %0h status %0d length %0d", k, d, s, l);
        errors++;
        return;
      end
      w = expected_q.pop_front();
      if (k !== w.kind) begin
        $error("event_kind: expected %0d, got %0d", w.kind, k);
        errors++;
      end
      if (d !== w.data) begin
        $error("data_byte: expected %0h, got %0h", w.data, d);
        errors++;
      end
      if (s !== w.status) begin
        $error("drop_status: expected %0d, got %0d", w.status, s);
        errors++;
      end
      if (l !== w.len) begin
        $error("frame_length: expected %0d, got %0d", w.len, l);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_command;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_event_kind;
  logic [7:0]  out_data_byte;
  logic [2:0]  out_drop_status;
  logic [15:0] out_frame_length;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_max_frame_length;

  deframe_scoreboard sb = new();

  int         gap_pct;
  int         stall_pct;
  bit         no_idle;
  bit         hold_req;
  int         items_sent;
  logic [7:0] body_q [$];
  logic [7:0] line_q [$];

  async_hdlc_rx_deframer_top uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_command           (in_command),
    .in_rx_byte           (in_rx_byte),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_event_kind       (out_event_kind),
    .out_data_byte        (out_data_byte),
    .out_drop_status      (out_drop_status),
    .out_frame_length     (out_frame_length),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_max_frame_length (cfg_max_frame_length)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        sb.check_word(out_event_kind, out_data_byte, out_drop_status, out_frame_length);
      end
    end
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (300) @(negedge clk);
        out_stall <= 1'b0;
      end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // entered and left at a falling edge
  task automatic send_word(input logic cmd, input logic [7:0] b);
    int gap;
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    sb.note_word(cmd, b);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_line();
    foreach (line_q[i]) begin
      send_word(ahdlc_pkg::CMD_BYTE, line_q[i]);
    end
  endtask

  task automatic drain_all();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_max_len(input logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_max_frame_length <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.max_len = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic fill_body(input int n);
    int r;
    body_q.delete();
    repeat (n) begin
      r = $urandom_range(0, 15);
      if (r == 0) begin
        body_q.push_back(ahdlc_pkg::FLAG_BYTE);
      end else if (r == 1) begin
        body_q.push_back(ahdlc_pkg::ESC_BYTE);
      end else begin
        body_q.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // body_q + FCS, stuffed, closing flag -> line_q
  task automatic build_frame(input bit corrupt, input int esc_pct);
    logic [15:0] crc;
    logic [7:0]  full [$];
    int          pos;
    crc = ahdlc_pkg::FCS_INIT;
    full = body_q;
    foreach (body_q[i]) begin
      crc = sb.crc_step(crc, body_q[i]);
    end
    crc = ~crc;
    full.push_back(crc[7:0]);
    full.push_back(crc[15:8]);
    if (corrupt) begin
      pos = $urandom_range(0, full.size() - 1);
      full[pos] = full[pos] ^ (8'h01 << $urandom_range(0, 7));
    end
    line_q.delete();
    foreach (full[i]) begin
      if (full[i] == ahdlc_pkg::FLAG_BYTE || full[i] == ahdlc_pkg::ESC_BYTE ||
          $urandom_range(0, 99) < esc_pct) begin
        line_q.push_back(ahdlc_pkg::ESC_BYTE);
        line_q.push_back(full[i] ^ ahdlc_pkg::ESC_XOR);
      end else begin
        line_q.push_back(full[i]);
      end
    end
    line_q.push_back(ahdlc_pkg::FLAG_BYTE);
  endtask

  task automatic random_traffic(input int n_items, input int max_body);
    int pick;
    int stop_at;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      if (no_idle || $urandom_range(0, 4) == 0) begin
        gap_pct = 0;
        stall_pct = 0;
      end else begin
        gap_pct = 20;
        stall_pct = 20;
      end
      pick = $urandom_range(0, 99);
      fill_body(($urandom_range(0, 9) == 0) ? max_body : $urandom_range(0, max_body));
      if (pick < 60) begin
        build_frame(1'b0, 10);
        send_line();
      end else if (pick < 72) begin
        build_frame(1'b1, 10);
        send_line();
      end else if (pick < 87) begin
        // abort partway: escaped flag or line error
        build_frame(1'b0, 10);
        repeat ($urandom_range(1, line_q.size())) line_q.delete(line_q.size() - 1);
        send_line();
        if (pick < 80) begin
          send_word(ahdlc_pkg::CMD_BYTE, ahdlc_pkg::ESC_BYTE);
          send_word(ahdlc_pkg::CMD_BYTE, ahdlc_pkg::FLAG_BYTE);
        end else begin
          send_word(ahdlc_pkg::CMD_ERROR, 8'($urandom_range(0, 255)));
        end
      end else if (pick < 93) begin
        repeat ($urandom_range(1, 8)) begin
          send_word(($urandom_range(0, 9) == 0) ? ahdlc_pkg::CMD_ERROR : ahdlc_pkg::CMD_BYTE,
                    8'($urandom_range(0, 255)));
        end
      end else begin
        send_word(ahdlc_pkg::CMD_BYTE, ahdlc_pkg::FLAG_BYTE);
      end
    end
  endtask

  initial begin
    int         short_byte;
    logic [7:0] b;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = 1'b0;
    in_rx_byte = 8'h00;
    cfg_valid = 1'b0;
    cfg_max_frame_length = 16'h0000;
    gap_pct = 20;
    stall_pct = 20;
    no_idle = 1'b0;
    hold_req = 1'b0;
    items_sent = 0;
    short_byte = -1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty frame, line error and escaped flag with nothing counted
    send_word(ahdlc_pkg::CMD_BYTE, ahdlc_pkg::FLAG_BYTE);
    send_word(ahdlc_pkg::CMD_ERROR, 8'hff);
    send_word(ahdlc_pkg::CMD_BYTE, ahdlc_pkg::ESC_BYTE);
    send_word(ahdlc_pkg::CMD_BYTE, ahdlc_pkg::FLAG_BYTE);
    body_q = '{8'h00, 8'hff, ahdlc_pkg::FLAG_BYTE, ahdlc_pkg::ESC_BYTE};
    build_frame(1'b0, 0);
    send_line();
    // FCS only: accepted with length 0
    body_q.delete();
    build_frame(1'b0, 0);
    send_line();
    // single byte with a good residue: too short
    for (int i = 0; i < 256; i++) begin
      if (sb.crc_step(ahdlc_pkg::FCS_INIT, 8'(i)) == ahdlc_pkg::FCS_GOOD) begin
        short_byte = i;
      end
    end
    if (short_byte >= 0) begin
      b = 8'(short_byte);
      if (b == ahdlc_pkg::FLAG_BYTE || b == ahdlc_pkg::ESC_BYTE) begin
        send_word(ahdlc_pkg::CMD_BYTE, ahdlc_pkg::ESC_BYTE);
        b = b ^ ahdlc_pkg::ESC_XOR;
      end
      send_word(ahdlc_pkg::CMD_BYTE, b);
      send_word(ahdlc_pkg::CMD_BYTE, ahdlc_pkg::FLAG_BYTE);
    end
    send_word(ahdlc_pkg::CMD_BYTE, 8'h01);
    send_word(ahdlc_pkg::CMD_BYTE, 8'h02);
    send_word(ahdlc_pkg::CMD_BYTE, 8'h03);
    send_word(ahdlc_pkg::CMD_BYTE, ahdlc_pkg::FLAG_BYTE);
    send_word(ahdlc_pkg::CMD_BYTE, 8'h11);
    send_word(ahdlc_pkg::CMD_ERROR, 8'h00);
    drain_all();

    // smallest limit: 4th data byte overruns
    write_max_len(16'd1);
    send_word(ahdlc_pkg::CMD_BYTE, 8'h31);
    send_word(ahdlc_pkg::CMD_BYTE, 8'h32);
    send_word(ahdlc_pkg::CMD_BYTE, 8'h33);
    send_word(ahdlc_pkg::CMD_BYTE, 8'h34);
    send_word(ahdlc_pkg::CMD_BYTE, ahdlc_pkg::FLAG_BYTE);
    body_q = '{8'h5a};
    build_frame(1'b0, 0);
    send_line();
    random_traffic(300, 4);
    drain_all();

    // largest limit
    write_max_len(16'd65533);
    random_traffic(100, 40);
    drain_all();

    write_max_len(16'd5);
    random_traffic(150, 10);
    hold_req = 1'b1;
    random_traffic(100, 10);
    drain_all();
    random_traffic(150, 10);
    drain_all();

    write_max_len(16'd1500);
    random_traffic(500, 30);
    no_idle = 1'b1;
    random_traffic(200, 30);

    in_valid <= 1'b0;
    for (int i = 0; i < 5000 && sb.expected_q.size() != 0; i++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.expected_q.size() != 0) begin
      $error("%0d expected output words never arrived", sb.expected_q.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/ahdlc_pkg.sv
rtl/async_hdlc_rx_deframer_top.sv
tb/tb_async_hdlc_rx_deframer_top.sv
